FILE: sv/assert_macros.svh
// Assertion macros used by the top level of the multiplier.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)
`endif
`endif

FILE: sv/tmul_pkg.sv
// Package with widths, stage records and the leading-one helper function of the multiplier.
`default_nettype none
package tmul_pkg;
    localparam int FRAC_BITS = 23;
    localparam int EXP_BITS  = 8;
    localparam int SIG_BITS  = FRAC_BITS + 1;
    localparam int PROD_BITS = 2 * SIG_BITS;
    localparam int LEAD_BITS = $clog2(PROD_BITS);
    localparam int ESUM_BITS = EXP_BITS + 1;

    typedef struct packed {
        logic                   valid;
        logic                   sign;
        logic                   special;
        logic                   zero;
        logic [ESUM_BITS-1:0]   esum;
        logic [PROD_BITS-1:0]   prod;
    } t_s1;

    typedef struct packed {
        logic                   valid;
        logic                   sign;
        logic                   special;
        logic                   zero;
        logic [ESUM_BITS-1:0]   esum;
        logic [PROD_BITS-1:0]   prod;
        logic [LEAD_BITS-1:0]   lead;
    } t_s2;

    // Position of the highest set bit; zero when no bit is set.
    function automatic logic [LEAD_BITS-1:0] f_lead(input logic [PROD_BITS-1:0] p);
        logic [LEAD_BITS-1:0] pos;
        pos = '0;
        for (int j = 0; j < PROD_BITS; j++) begin
            if (p[j]) begin
                pos = LEAD_BITS'(j);
            end
        end
        return pos;
    endfunction
endpackage
`default_nettype wire

FILE: sv/binary32_truncating_multiplier.sv
// Top level of the three-stage binary32 truncating multiplier.
//
//   channel  | direction | handshake             | payload
//   request  | in        | i_valid / o_stall     | i_operand_a, i_operand_b
//   result   | out       | o_valid / i_stall     | o_product
//
// A request accepted at the input passes the unpack, leading-one and pack
// registers in that order before it shows on o_valid; one request can enter
// every cycle while o_stall is low. The stages are the 24x24 multiplier, the
// leading-one search and the normalize/pack logic, each ending in a register.
// Reset is synchronous and clears only the stage valid bits.
// The whole pipe holds while the output register is full and stalled.
`default_nettype none
`include "assert_macros.svh"
module binary32_truncating_multiplier import tmul_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [31:0]      o_product
);
    logic advance;
    t_s1  s1;
    t_s2  s2;

    assign advance = !o_valid || !i_stall;
    assign o_stall = !advance;

    tmul_unpack u_unpack (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (advance),
        .i_valid     (i_valid),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_s1        (s1)
    );

    tmul_lzc u_lzc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (advance),
        .i_s1    (s1),
        .o_s2    (s2)
    );

    tmul_pack u_pack (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (advance),
        .i_s2      (s2),
        .o_valid   (o_valid),
        .o_product (o_product)
    );

    `ASSERT_CLK(a_stall_needs_valid, i_clk, i_rst_n, o_stall |-> o_valid)
    `ASSERT_CLK(a_s2_reaches_out, i_clk, i_rst_n, (s2.valid && advance) |=> o_valid)
    `ASSERT_CLK(a_s1_holds, i_clk, i_rst_n, o_stall |=> ($stable(s1) && $stable(s2)))
    `ASSERT_NEVER(a_lead_nonzero_prod, i_clk, i_rst_n,
        s2.valid && !s2.zero && !s2.special && (s2.prod == '0))
endmodule
`default_nettype wire

FILE: sv/tmul_unpack.sv
// First stage: operand classification and the significand multiply.
`default_nettype none
module tmul_unpack import tmul_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  wire logic        i_valid,
    input  wire logic [31:0] i_operand_a,
    input  wire logic [31:0] i_operand_b,
    output t_s1              o_s1
);
    logic [EXP_BITS-1:0]  ea, eb;
    logic [SIG_BITS-1:0]  ma, mb;
    logic [ESUM_BITS-1:0] ba, bb;
    t_s1 r_s1, n_s1;

    always_comb begin
        ea = i_operand_a[30:23];
        eb = i_operand_b[30:23];
        ma = {ea != '0, i_operand_a[FRAC_BITS-1:0]};
        mb = {eb != '0, i_operand_b[FRAC_BITS-1:0]};
        // A subnormal counts as biased exponent one.
        ba = (ea != '0) ? {1'b0, ea} : ESUM_BITS'(1);
        bb = (eb != '0) ? {1'b0, eb} : ESUM_BITS'(1);
        n_s1.valid   = i_valid;
        n_s1.sign    = i_operand_a[31] ^ i_operand_b[31];
        n_s1.special = (ea == '1) || (eb == '1);
        n_s1.zero    = (i_operand_a[30:0] == '0) || (i_operand_b[30:0] == '0);
        n_s1.esum    = ba + bb;
        n_s1.prod    = PROD_BITS'(ma) * PROD_BITS'(mb);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else if (i_en) begin
            r_s1.valid <= n_s1.valid;
        end
        if (i_en) begin
            r_s1.sign    <= n_s1.sign;
            r_s1.special <= n_s1.special;
            r_s1.zero    <= n_s1.zero;
            r_s1.esum    <= n_s1.esum;
            r_s1.prod    <= n_s1.prod;
        end
    end

    assign o_s1 = r_s1;
endmodule
`default_nettype wire

FILE: sv/tmul_lzc.sv
// Second stage: leading-one search on the significand product.
`default_nettype none
module tmul_lzc import tmul_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_en,
    input  t_s1       i_s1,
    output t_s2       o_s2
);
    t_s2 r_s2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
        end else if (i_en) begin
            r_s2.valid <= i_s1.valid;
        end
        if (i_en) begin
            r_s2.sign    <= i_s1.sign;
            r_s2.special <= i_s1.special;
            r_s2.zero    <= i_s1.zero;
            r_s2.esum    <= i_s1.esum;
            r_s2.prod    <= i_s1.prod;
            r_s2.lead    <= f_lead(i_s1.prod);
        end
    end

    assign o_s2 = r_s2;
endmodule
`default_nettype wire

FILE: sv/tmul_pack.sv
// Third stage: normalize, handle the special cases and register the product.
`default_nettype none
module tmul_pack import tmul_pkg::*; (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_en,
    input  t_s2              i_s2,
    output logic             o_valid,
    output logic [31:0]      o_product
);
    localparam int XW = 2 * PROD_BITS + 1;

    logic signed [10:0]    sum;
    logic signed [10:0]    k;
    logic [PROD_BITS-1:0]  norm;
    logic [FRAC_BITS-1:0]  frac;
    logic [5:0]            shamt;
    logic [XW-1:0]         x;
    logic [PROD_BITS-1:0]  q;
    logic                  rnd;
    logic [30:0]           small_mag;
    logic [31:0]           n_product;
    logic                  r_valid;
    logic [31:0]           r_product;

    always_comb begin
        sum   = $signed({2'b0, i_s2.esum}) + $signed({5'b0, i_s2.lead}) - 11'sd173;
        k     = 11'sd151 - $signed({2'b0, i_s2.esum});
        norm  = i_s2.prod << (6'd47 - i_s2.lead);
        // When the leading one lies below bit 23, the fraction is set to zero.
        frac  = (i_s2.lead < 6'd23) ? '0 : norm[PROD_BITS-2 -: FRAC_BITS];
        shamt = k[5:0];
        x     = {i_s2.prod, {(PROD_BITS+1){1'b0}}} >> shamt;
        q     = x[XW-1 -: PROD_BITS];
        rnd   = x[PROD_BITS] && ((|x[PROD_BITS-1:0]) || q[0]);
        if (k >= 11'sd50) begin
            small_mag = '0;
        end else begin
            small_mag = q[30:0] + 31'(rnd);
        end
        if (i_s2.special) begin
            n_product = {i_s2.sign, 31'h7FFFFFFF};
        end else if (i_s2.zero) begin
            n_product = {i_s2.sign, 31'h0};
        end else if (sum < 0) begin
            n_product = {i_s2.sign, small_mag};
        end else if (sum >= 11'sd255) begin
            n_product = {i_s2.sign, 8'hFF, 23'h0};
        end else begin
            n_product = {i_s2.sign, sum[7:0], frac};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_s2.valid;
        end
        if (i_en) begin
            r_product <= n_product;
        end
    end

    assign o_valid   = r_valid;
    assign o_product = r_product;
endmodule
`default_nettype wire
